// ===== hdl/lcd_shadow_buffer_refresh_macros.svh =====
// Assertion macros used by the checker of the display refresh block.
`ifndef LCD_SHADOW_BUFFER_REFRESH_MACROS_SVH
`define LCD_SHADOW_BUFFER_REFRESH_MACROS_SVH

// The antecedent holds in a cycle, and the consequent holds in the same cycle.
`define LSBR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcd_shadow_buffer_refresh: same-cycle check failed");

// The antecedent holds in a cycle, and the consequent holds in the next cycle.
`define LSBR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcd_shadow_buffer_refresh: next-cycle check failed");

`endif

// ===== hdl/lsbr_pkg.sv =====
// Types and constants of the display shadow-buffer refresh block.
package lsbr_pkg;

    localparam int NUM_LINES_DEF   = 2;
    localparam int NUM_COLUMNS_DEF = 20;

    localparam int LINE_W = 1;
    localparam int COL_W  = 6;
    localparam int CODE_W = 8;
    localparam int NIB_W  = 4;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    localparam logic RS_COMMAND = 1'b0;
    localparam logic RS_DATA    = 1'b1;

    localparam logic SET_ADDR_BIT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        NIB_CMD_HI,
        NIB_CMD_LO,
        NIB_DATA_HI,
        NIB_DATA_LO
    } nib_sel_t;

endpackage

// ===== hdl/lcd_shadow_buffer_refresh.sv =====
// Shadow buffer of character codes with a scanning refresher for a 4-bit display bus.
// A write transfer leaves busy low.
// A tick reads the buffer memory once per cycle into a registered read stage: it scans all
// positions, starting after the last one shown, then shows 4 nibbles if a position was pending.
// Results cannot be stalled; the next transfer is taken only once busy is low again after a tick.
// Reset clears the per-position valid bits and the scan position at once; no clearing pass.
module lcd_shadow_buffer_refresh #(
    parameter int NUM_LINES   = lsbr_pkg::NUM_LINES_DEF,
    parameter int NUM_COLUMNS = lsbr_pkg::NUM_COLUMNS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       kind,
    input  logic [lsbr_pkg::LINE_W-1:0] line,
    input  logic [lsbr_pkg::COL_W-1:0]  column,
    input  logic [lsbr_pkg::CODE_W-1:0] char_code,
    output logic                       strobe,
    output logic [lsbr_pkg::NIB_W-1:0]  nibble,
    output logic                       register_select,
    output logic                       last
);

    localparam int CELLS = NUM_LINES * NUM_COLUMNS;
    localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_W = $clog2(CELLS + 1);

    lsbr_pkg::state_t state_reg, state_next;

    logic [lsbr_pkg::CODE_W-1:0] mem [CELLS];
    logic [CELLS-1:0]            valid_reg;
    logic [lsbr_pkg::CODE_W-1:0] rd_data_reg;
    logic                        rd_vld_reg;

    logic [IDX_W-1:0]            scan_idx_reg, scan_idx_next;
    logic [lsbr_pkg::LINE_W-1:0] scan_ln_reg, scan_ln_next;
    logic [lsbr_pkg::COL_W-1:0]  scan_col_reg, scan_col_next;

    logic [IDX_W-1:0]            iss_idx_reg, iss_idx_next;
    logic [lsbr_pkg::LINE_W-1:0] iss_ln_reg, iss_ln_next;
    logic [lsbr_pkg::COL_W-1:0]  iss_col_reg, iss_col_next;
    logic [CNT_W-1:0]            iss_cnt_reg, iss_cnt_next;

    logic                        chk_valid_reg, chk_valid_next;
    logic                        chk_last_reg;
    logic [IDX_W-1:0]            chk_idx_reg;
    logic [lsbr_pkg::LINE_W-1:0] chk_ln_reg;
    logic [lsbr_pkg::COL_W-1:0]  chk_col_reg;

    logic [lsbr_pkg::LINE_W-1:0] out_ln_reg;
    logic [lsbr_pkg::COL_W-1:0]  out_col_reg;
    logic [lsbr_pkg::CODE_W-1:0] out_data_reg;
    lsbr_pkg::nib_sel_t          nib_sel_reg, nib_sel_next;

    logic [IDX_W-1:0]            base_idx, step_idx;
    logic [lsbr_pkg::LINE_W-1:0] base_ln, step_ln;
    logic [lsbr_pkg::COL_W-1:0]  base_col, step_col;

    logic                        accept_write, accept_tick;
    logic                        write_in_range;
    logic [IDX_W-1:0]            write_addr;
    logic                        issue_en;
    logic [lsbr_pkg::CODE_W-1:0] chk_code;
    logic                        found, exhausted;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    logic [lsbr_pkg::CODE_W-1:0] wr_data;
    logic [lsbr_pkg::CODE_W-1:0] cmd_byte;

    assign busy         = (state_reg != lsbr_pkg::ST_IDLE);
    assign accept_write = start && !busy && (kind == lsbr_pkg::KIND_WRITE);
    assign accept_tick  = start && !busy && (kind == lsbr_pkg::KIND_TICK);

    assign write_in_range = (32'(line) < NUM_LINES) && (32'(column) < NUM_COLUMNS);
    assign write_addr     = IDX_W'(32'(line) * NUM_COLUMNS + 32'(column));

    assign chk_code  = rd_vld_reg ? rd_data_reg : '0;
    assign found     = (state_reg == lsbr_pkg::ST_SCAN) && chk_valid_reg && (chk_code != '0);
    assign exhausted = (state_reg == lsbr_pkg::ST_SCAN) && chk_valid_reg && chk_last_reg
                       && !found;
    assign issue_en  = (state_reg == lsbr_pkg::ST_SCAN) && (iss_cnt_reg != CNT_W'(CELLS))
                       && !found && !exhausted;

    always_comb
    begin
        if (state_reg == lsbr_pkg::ST_IDLE)
        begin
            base_idx = scan_idx_reg;
            base_ln  = scan_ln_reg;
            base_col = scan_col_reg;
        end
        else
        begin
            base_idx = iss_idx_reg;
            base_ln  = iss_ln_reg;
            base_col = iss_col_reg;
        end
        step_idx = (base_idx == IDX_W'(CELLS - 1)) ? '0 : base_idx + 1'b1;
        step_ln  = base_ln;
        step_col = base_col + 1'b1;
        if (base_col == lsbr_pkg::COL_W'(NUM_COLUMNS - 1))
        begin
            step_col = '0;
            step_ln  = (base_ln == lsbr_pkg::LINE_W'(NUM_LINES - 1)) ? '0 : base_ln + 1'b1;
        end
    end

    always_comb
    begin
        iss_idx_next   = iss_idx_reg;
        iss_ln_next    = iss_ln_reg;
        iss_col_next   = iss_col_reg;
        iss_cnt_next   = iss_cnt_reg;
        chk_valid_next = issue_en;
        if (accept_tick || issue_en)
        begin
            iss_idx_next = step_idx;
            iss_ln_next  = step_ln;
            iss_col_next = step_col;
            iss_cnt_next = accept_tick ? '0 : iss_cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        scan_idx_next = scan_idx_reg;
        scan_ln_next  = scan_ln_reg;
        scan_col_next = scan_col_reg;
        if (found)
        begin
            scan_idx_next = chk_idx_reg;
            scan_ln_next  = chk_ln_reg;
            scan_col_next = chk_col_reg;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = write_addr;
        wr_data = char_code;
        if (found)
        begin
            wr_en   = 1'b1;
            wr_addr = chk_idx_reg;
            wr_data = '0;
        end
        else if (accept_write && write_in_range)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        nib_sel_next = nib_sel_reg;
        unique case (state_reg)
            lsbr_pkg::ST_IDLE:
            begin
                if (accept_tick)
                begin
                    state_next = lsbr_pkg::ST_SCAN;
                end
            end
            lsbr_pkg::ST_SCAN:
            begin
                if (found)
                begin
                    state_next   = lsbr_pkg::ST_EMIT;
                    nib_sel_next = lsbr_pkg::NIB_CMD_HI;
                end
                else if (exhausted)
                begin
                    state_next = lsbr_pkg::ST_IDLE;
                end
            end
            lsbr_pkg::ST_EMIT:
            begin
                unique case (nib_sel_reg)
                    lsbr_pkg::NIB_CMD_HI:  nib_sel_next = lsbr_pkg::NIB_CMD_LO;
                    lsbr_pkg::NIB_CMD_LO:  nib_sel_next = lsbr_pkg::NIB_DATA_HI;
                    lsbr_pkg::NIB_DATA_HI: nib_sel_next = lsbr_pkg::NIB_DATA_LO;
                    lsbr_pkg::NIB_DATA_LO: state_next   = lsbr_pkg::ST_IDLE;
                    default:               state_next   = lsbr_pkg::ST_IDLE;
                endcase
            end
            default:
            begin
                state_next = lsbr_pkg::ST_IDLE;
            end
        endcase
    end

    assign cmd_byte = {lsbr_pkg::SET_ADDR_BIT, out_ln_reg, out_col_reg};

    always_comb
    begin
        strobe          = (state_reg == lsbr_pkg::ST_EMIT);
        nibble          = cmd_byte[7:4];
        register_select = lsbr_pkg::RS_COMMAND;
        last            = 1'b0;
        case (nib_sel_reg)
            lsbr_pkg::NIB_CMD_HI:
            begin
                nibble = cmd_byte[7:4];
            end
            lsbr_pkg::NIB_CMD_LO:
            begin
                nibble = cmd_byte[3:0];
            end
            lsbr_pkg::NIB_DATA_HI:
            begin
                nibble          = out_data_reg[7:4];
                register_select = lsbr_pkg::RS_DATA;
            end
            lsbr_pkg::NIB_DATA_LO:
            begin
                nibble          = out_data_reg[3:0];
                register_select = lsbr_pkg::RS_DATA;
                last            = strobe;
            end
            default:
            begin
                nibble = cmd_byte[7:4];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue_en)
        begin
            rd_data_reg <= mem[iss_idx_reg];
            rd_vld_reg  <= valid_reg[iss_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsbr_pkg::ST_IDLE;
            nib_sel_reg   <= lsbr_pkg::NIB_CMD_HI;
            chk_valid_reg <= 1'b0;
            scan_idx_reg  <= '0;
            scan_ln_reg   <= '0;
            scan_col_reg  <= '0;
            iss_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            nib_sel_reg   <= nib_sel_next;
            chk_valid_reg <= chk_valid_next;
            scan_idx_reg  <= scan_idx_next;
            scan_ln_reg   <= scan_ln_next;
            scan_col_reg  <= scan_col_next;
            iss_cnt_reg   <= iss_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_idx_reg <= iss_idx_next;
        iss_ln_reg  <= iss_ln_next;
        iss_col_reg <= iss_col_next;
        if (issue_en)
        begin
            chk_last_reg <= (iss_cnt_reg == CNT_W'(CELLS - 1));
            chk_idx_reg  <= iss_idx_reg;
            chk_ln_reg   <= iss_ln_reg;
            chk_col_reg  <= iss_col_reg;
        end
        if (found)
        begin
            out_ln_reg   <= chk_ln_reg;
            out_col_reg  <= chk_col_reg;
            out_data_reg <= chk_code;
        end
    end

endmodule

// ===== hdl/lsbr_checker.sv =====
// Port-level checker of the display refresh block, bound to its top level.
`include "lcd_shadow_buffer_refresh_macros.svh"

module lsbr_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic kind,
    input logic strobe,
    input logic register_select,
    input logic last
);

    `LSBR_ASSERT_SAME(a_strobe_busy, strobe, busy)
    `LSBR_ASSERT_NEXT(a_tick_busy, start && !busy && (kind == lsbr_pkg::KIND_TICK), busy)
    `LSBR_ASSERT_SAME(a_last_data, strobe && last, register_select == lsbr_pkg::RS_DATA)
    `LSBR_ASSERT_NEXT(a_cmd_follow, strobe && (register_select == lsbr_pkg::RS_COMMAND), strobe)
    `LSBR_ASSERT_NEXT(a_last_idle, strobe && last, !busy && !strobe)

endmodule

bind lcd_shadow_buffer_refresh lsbr_checker u_lsbr_checker (.*);
